### src/heightmap_bilinear_sampler_macros.svh
// Assertion macros for the height map sampler.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define HBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbs: implication violated");

// Next-cycle implication, inactive during reset.
`define HBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbs: next-cycle implication violated");

`endif

### src/hbs_pkg.sv
`default_nettype none
package hbs_pkg;

    localparam int MAX_SIZE_LOG2_DEF = 8;
    localparam int QUEUE_DEPTH       = 4;

    localparam int SAMPLE_W = 16;
    localparam int COORD_W  = 24;
    localparam int FRAC_W   = 8;
    localparam int HEIGHT_W = 32;
    localparam int TOP_W    = 24;
    localparam int LG_W     = 4;

    localparam logic [LG_W-1:0] SIZE_LOG2_RESET = 4'd8;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic REG_SIZE_LOG2 = 1'b0;
    localparam logic REG_MAP_VALID = 1'b1;

    typedef enum logic [2:0] {
        OP_WRITE = 3'b001,
        OP_QUERY = 3'b010,
        OP_ZERO  = 3'b100
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [FRAC_W-1:0]   fx;
        logic [FRAC_W-1:0]   fz;
        logic                swap;
        logic                lg_zero;
        logic                wbank;
        logic [SAMPLE_W-1:0] wdata;
    } t_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

### src/hbs_front.sv
`default_nettype none
module hbs_front #(
    parameter int MAX_SIZE_LOG2 = hbs_pkg::MAX_SIZE_LOG2_DEF
) (
    input  logic                                i_func,
    input  logic [15:0]                         i_write_index,
    input  logic [hbs_pkg::SAMPLE_W-1:0]        i_write_height,
    input  logic signed [hbs_pkg::COORD_W-1:0]  i_query_x,
    input  logic signed [hbs_pkg::COORD_W-1:0]  i_query_z,
    input  logic [hbs_pkg::LG_W-1:0]            i_size_log2,
    input  logic                                i_map_valid,
    output hbs_pkg::t_ctl                       o_ctl,
    output logic [2*MAX_SIZE_LOG2-2:0]          o_addr_e0,
    output logic [2*MAX_SIZE_LOG2-2:0]          o_addr_e1,
    output logic [2*MAX_SIZE_LOG2-2:0]          o_addr_o0,
    output logic [2*MAX_SIZE_LOG2-2:0]          o_addr_o1
);

    localparam int M     = MAX_SIZE_LOG2;
    localparam int IDX_W = 2 * M;
    localparam int FW    = hbs_pkg::FRAC_W;
    localparam int CW    = hbs_pkg::COORD_W;

    logic [hbs_pkg::LG_W-1:0] lg;
    logic [M:0]               side;
    logic [M-1:0]             mask;
    logic [M-1:0]             xi, zi;
    logic [M-1:0]             x0, x1, z0, z1;
    logic [M-1:0]             x_even, x_odd;
    logic [IDX_W-1:0]         rb0, rb1;
    logic [IDX_W-1:0]         idx_e0, idx_e1, idx_o0, idx_o1;
    logic [IDX_W-1:0]         widx;
    logic                     is_write;

    assign lg   = (i_size_log2 > hbs_pkg::LG_W'(M)) ? hbs_pkg::LG_W'(M) : i_size_log2;
    assign side = (M+1)'(1) << lg;
    assign mask = M'(side - 1'b1);

    assign xi = i_query_x[FW +: M];
    assign zi = i_query_z[FW +: M];

    assign x0 = xi & mask;
    assign x1 = M'(xi + 1'b1) & mask;
    assign z0 = zi & mask;
    assign z1 = M'(zi + 1'b1) & mask;

    assign x_even = x0[0] ? x1 : x0;
    assign x_odd  = x0[0] ? x0 : x1;

    assign rb0 = IDX_W'(z0) << lg;
    assign rb1 = IDX_W'(z1) << lg;

    assign idx_e0 = rb0 | IDX_W'(x_even);
    assign idx_e1 = rb1 | IDX_W'(x_even);
    assign idx_o0 = rb0 | IDX_W'(x_odd);
    assign idx_o1 = rb1 | IDX_W'(x_odd);

    assign widx     = IDX_W'(i_write_index);
    assign is_write = (i_func == hbs_pkg::FUNC_WRITE);

    assign o_addr_e0 = is_write ? widx[IDX_W-1:1] : idx_e0[IDX_W-1:1];
    assign o_addr_e1 = idx_e1[IDX_W-1:1];
    assign o_addr_o0 = idx_o0[IDX_W-1:1];
    assign o_addr_o1 = idx_o1[IDX_W-1:1];

    always_comb begin
        o_ctl.op = is_write ? hbs_pkg::OP_WRITE
                 : (i_map_valid ? hbs_pkg::OP_QUERY : hbs_pkg::OP_ZERO);
        o_ctl.fx      = i_query_x[FW-1:0];
        o_ctl.fz      = i_query_z[FW-1:0];
        o_ctl.swap    = x0[0];
        o_ctl.lg_zero = (lg == '0);
        o_ctl.wbank   = widx[0];
        o_ctl.wdata   = i_write_height;
    end

    logic unused_hi;
    assign unused_hi = ^{i_query_x[CW-1:FW+M], i_query_z[CW-1:FW+M]};

endmodule
`default_nettype wire

### src/hbs_queue.sv
`default_nettype none
module hbs_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = hbs_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output hbs_pkg::t_qstat   o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule
`default_nettype wire

### src/hbs_bank.sv
`default_nettype none
module hbs_bank #(
    parameter int AW = 15,
    parameter int DW = hbs_pkg::SAMPLE_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

### src/hbs_back.sv
`default_nettype none
module hbs_back #(
    parameter int MAX_SIZE_LOG2 = hbs_pkg::MAX_SIZE_LOG2_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hbs_pkg::t_ctl                 i_ctl,
    input  logic [2*MAX_SIZE_LOG2-2:0]    i_addr_e0,
    input  logic [2*MAX_SIZE_LOG2-2:0]    i_addr_e1,
    input  logic [2*MAX_SIZE_LOG2-2:0]    i_addr_o0,
    input  logic [2*MAX_SIZE_LOG2-2:0]    i_addr_o1,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hbs_pkg::HEIGHT_W-1:0]  o_height
);

    localparam int AW  = 2 * MAX_SIZE_LOG2 - 1;
    localparam int SW  = hbs_pkg::SAMPLE_W;
    localparam int FW  = hbs_pkg::FRAC_W;
    localparam int TW  = hbs_pkg::TOP_W;
    localparam int HW  = hbs_pkg::HEIGHT_W;
    localparam int WW  = FW + 1;
    localparam int PW  = TW + 1;
    localparam int QW  = HW + 1;

    logic          en;
    logic          is_write;
    logic [SW-1:0] ev_a, ev_b, od_a, od_b;

    logic          r_s1_valid;
    logic          r_s1_zero;
    logic [FW-1:0] r_s1_fx, r_s1_fz;
    logic          r_s1_swap, r_s1_lgz;

    logic          r_s2_valid;
    logic          r_s2_zero;
    logic [FW-1:0] r_s2_fz;
    logic [TW-1:0] r_s2_top, r_s2_bot;
    logic [TW-1:0] n_top, n_bot;

    logic          r_out_valid;
    logic [HW-1:0] r_height, n_height;

    logic [SW-1:0] h00, h10, h01, h11;
    logic [WW-1:0] wx0, wx1, wz0, wz1;

    assign en       = !(r_out_valid && i_stall);
    assign o_pop    = en && !i_empty;
    assign is_write = (i_ctl.op == hbs_pkg::OP_WRITE);

    hbs_bank #(.AW(AW), .DW(SW)) u_bank_even (
        .i_clk     (i_clk),
        .i_we      (o_pop && is_write && !i_ctl.wbank),
        .i_waddr   (i_addr_e0),
        .i_wdata   (i_ctl.wdata),
        .i_re      (en),
        .i_raddr_a (i_addr_e0),
        .i_raddr_b (i_addr_e1),
        .o_rdata_a (ev_a),
        .o_rdata_b (ev_b)
    );

    hbs_bank #(.AW(AW), .DW(SW)) u_bank_odd (
        .i_clk     (i_clk),
        .i_we      (o_pop && is_write && i_ctl.wbank),
        .i_waddr   (i_addr_e0),
        .i_wdata   (i_ctl.wdata),
        .i_re      (en),
        .i_raddr_a (i_addr_o0),
        .i_raddr_b (i_addr_o1),
        .o_rdata_a (od_a),
        .o_rdata_b (od_b)
    );

    assign h00 = r_s1_swap ? od_a : ev_a;
    assign h01 = r_s1_swap ? od_b : ev_b;
    assign h10 = (r_s1_lgz || r_s1_swap) ? ev_a : od_a;
    assign h11 = (r_s1_lgz || r_s1_swap) ? ev_b : od_b;

    assign wx1 = {1'b0, r_s1_fx};
    assign wx0 = WW'(9'd256 - wx1);
    assign wz1 = {1'b0, r_s2_fz};
    assign wz0 = WW'(9'd256 - wz1);

    assign n_top = TW'(PW'(h00) * PW'(wx0) + PW'(h10) * PW'(wx1));
    assign n_bot = TW'(PW'(h01) * PW'(wx0) + PW'(h11) * PW'(wx1));
    assign n_height = r_s2_zero ? '0
                    : HW'(QW'(r_s2_top) * QW'(wz0) + QW'(r_s2_bot) * QW'(wz1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= o_pop && !is_write;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_zero <= (i_ctl.op == hbs_pkg::OP_ZERO);
            r_s1_fx   <= i_ctl.fx;
            r_s1_fz   <= i_ctl.fz;
            r_s1_swap <= i_ctl.swap;
            r_s1_lgz  <= i_ctl.lg_zero;
            r_s2_zero <= r_s1_zero;
            r_s2_fz   <= r_s1_fz;
            r_s2_top  <= n_top;
            r_s2_bot  <= n_bot;
            r_height  <= n_height;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_height = r_height;

endmodule
`default_nettype wire

### src/heightmap_bilinear_sampler.sv
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-------------------------------------
// in        | to block  | i_in_valid / o_in_stall   | func, write_index, write_height, x, z
// out       | from block| o_out_valid / i_out_stall | height
// config    | to block  | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One transaction per cycle sustained unless the output stalls; a query result leaving the
// four-entry queue passes the two-read-port even/odd column banks and two multiply stages.
// Write transactions update the banks at queue exit and produce no result.
// A stalled output freezes the whole back end; the input stalls only when the queue is full.
// Reset clears control state, size_log2 to 8 and map_valid to 0; the map is not cleared.
`default_nettype none
`include "heightmap_bilinear_sampler_macros.svh"
module heightmap_bilinear_sampler #(
    parameter int MAX_SIZE_LOG2 = hbs_pkg::MAX_SIZE_LOG2_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [15:0]                         i_write_index,
    input  logic [hbs_pkg::SAMPLE_W-1:0]        i_write_height,
    input  logic signed [hbs_pkg::COORD_W-1:0]  i_query_x,
    input  logic signed [hbs_pkg::COORD_W-1:0]  i_query_z,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [hbs_pkg::HEIGHT_W-1:0]        o_height,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int AW    = 2 * MAX_SIZE_LOG2 - 1;
    localparam int CTL_W = $bits(hbs_pkg::t_ctl);
    localparam int Q_W   = CTL_W + 4 * AW;
    localparam int LW    = hbs_pkg::LG_W;

    logic [LW-1:0] r_size_log2;
    logic          r_map_valid;
    logic          cfg_wr;
    logic          reg_sel;

    hbs_pkg::t_ctl   f_ctl, b_ctl;
    logic [AW-1:0]   f_e0, f_e1, f_o0, f_o1;
    logic [AW-1:0]   b_e0, b_e1, b_o0, b_o1;
    logic [Q_W-1:0]  q_out;
    hbs_pkg::t_qstat w_qstat;
    logic            w_push, w_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= hbs_pkg::SIZE_LOG2_RESET;
            r_map_valid <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_sel)
                hbs_pkg::REG_SIZE_LOG2: r_size_log2 <= pwdata[LW-1:0];
                hbs_pkg::REG_MAP_VALID: r_map_valid <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            hbs_pkg::REG_SIZE_LOG2: prdata = 32'(r_size_log2);
            hbs_pkg::REG_MAP_VALID: prdata = 32'(r_map_valid);
            default:                prdata = '0;
        endcase
    end

    hbs_front #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_front (
        .i_func         (i_func),
        .i_write_index  (i_write_index),
        .i_write_height (i_write_height),
        .i_query_x      (i_query_x),
        .i_query_z      (i_query_z),
        .i_size_log2    (r_size_log2),
        .i_map_valid    (r_map_valid),
        .o_ctl          (f_ctl),
        .o_addr_e0      (f_e0),
        .o_addr_e1      (f_e1),
        .o_addr_o0      (f_o0),
        .o_addr_o1      (f_o1)
    );

    assign w_push     = i_in_valid && !w_qstat.full;
    assign o_in_stall = w_qstat.full;

    hbs_queue #(.DATA_W(Q_W), .DEPTH(hbs_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({f_ctl, f_e0, f_e1, f_o0, f_o1}),
        .i_pop   (w_pop),
        .o_data  (q_out),
        .o_stat  (w_qstat)
    );

    assign {b_ctl, b_e0, b_e1, b_o0, b_o1} = q_out;

    hbs_back #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (b_ctl),
        .i_addr_e0 (b_e0),
        .i_addr_e1 (b_e1),
        .i_addr_o0 (b_o0),
        .i_addr_o1 (b_o1),
        .i_empty   (w_qstat.empty),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_height  (o_height)
    );

    `HBS_ASSERT_IMP(a_pop_needs_entry, i_clk, i_rst_n, w_pop, !w_qstat.empty)
    `HBS_ASSERT_NXT(a_push_leaves_entry, i_clk, i_rst_n, w_push, !w_qstat.empty)
    `HBS_ASSERT_IMP(a_queue_status_sane, i_clk, i_rst_n, 1'b1, !(w_qstat.full && w_qstat.empty))

endmodule
`default_nettype wire
